### hw/rtl/pset_pkg.sv
// Package for the periodic segment event timer: register indexes, fixed
// register widths and the sequencer state type.
// Depends on nothing; used by the top level and the testbench.
package pset_pkg;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_EVENT_BITS = 16;
  // The sum of two 32-bit segment lengths needs one more bit.
  localparam int PERIOD_BITS = 33;

  localparam logic [CFG_ADDR_BITS-1:0] REG_START_TIME    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TIME_SHIFT    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_LENGTH  = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_EVENT   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_LENGTH = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_EVENT  = 3'd5;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_DIV      = 9'b000000100,
    S_NEG      = 9'b000001000,
    S_POS_ADD  = 9'b000010000,
    S_POS_WRAP = 9'b000100000,
    S_SEG      = 9'b001000000,
    S_DUE      = 9'b010000000,
    S_OUT      = 9'b100000000
  } pset_state_t;

endpackage

### hw/rtl/periodic_segment_event_timer_unit.sv
// Top level of the periodic segment event timer: configuration registers,
// sequencer, shared restoring remainder unit and output register.
// Depends on pset_pkg.

// Each request carries the current time. A request that finds the period empty
// or the due time not yet reached goes from the check state straight to output.
// A request that fires runs two remainders through one shared restoring unit
// that retires one dividend bit per cycle, first the shift modulo the period,
// then the elapsed time modulo the period, and then adds, wraps, picks the
// segment and sets the due time before output. The input is not ready while a
// request is in work; a finished result waits in the output register while the
// next request is taken.
module periodic_segment_event_timer_unit #(
  parameter int TIME_BITS  = 32,
  parameter int EVENT_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // Configuration write port.
  input  logic                                        cfg_wr_en,
  input  logic [pset_pkg::CFG_ADDR_BITS-1:0]          cfg_addr,
  input  logic [pset_pkg::CFG_DATA_BITS-1:0]          cfg_wdata,
  // Time requests.
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0]              in_tdata,   // now
  // Results.
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // event_code, next_due, sleep_seconds
  output logic [((EVENT_BITS+2*TIME_BITS+7)/8)*8-1:0] out_tdata,
  output logic [1:0]                                  out_tuser   // fired, period_empty
);

  localparam int DW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int CW = $clog2(DW);
  localparam int SW = ((TIME_BITS > pset_pkg::PERIOD_BITS) ? TIME_BITS
                                                          : pset_pkg::PERIOD_BITS) + 1;
  localparam int PB = pset_pkg::PERIOD_BITS;
  localparam int OUT_W = ((EVENT_BITS + 2*TIME_BITS + 7) / 8) * 8;
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  // Configuration registers.
  logic [31:0] start_time_r, time_shift_r, first_length_r, second_length_r;
  logic [pset_pkg::REG_EVENT_BITS-1:0] first_event_r, second_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r    <= '0;
      time_shift_r    <= '0;
      first_length_r  <= '0;
      first_event_r   <= '0;
      second_length_r <= '0;
      second_event_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        pset_pkg::REG_START_TIME:    start_time_r    <= cfg_wdata;
        pset_pkg::REG_TIME_SHIFT:    time_shift_r    <= cfg_wdata;
        pset_pkg::REG_FIRST_LENGTH:  first_length_r  <= cfg_wdata;
        pset_pkg::REG_FIRST_EVENT:   first_event_r   <= cfg_wdata[pset_pkg::REG_EVENT_BITS-1:0];
        pset_pkg::REG_SECOND_LENGTH: second_length_r <= cfg_wdata;
        pset_pkg::REG_SECOND_EVENT:  second_event_r  <= cfg_wdata[pset_pkg::REG_EVENT_BITS-1:0];
        default: ;
      endcase
    end
  end

  pset_pkg::pset_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] due_r, due_nxt;
  logic [TIME_BITS-1:0] next_r, next_nxt;
  logic [PB-1:0]        period_r, period_nxt;
  logic [DW-1:0]        div_r, div_nxt;
  logic [PB-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [PB-1:0]        shift_r, shift_nxt;
  logic [PB:0]          acc_r, acc_nxt;
  logic [pset_pkg::REG_EVENT_BITS-1:0] code_r, code_nxt;
  logic                 fired_r, fired_nxt;
  logic                 empty_r, empty_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fired_r, out_fired_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [EVENT_BITS-1:0] out_code_r, out_code_nxt;
  logic [TIME_BITS-1:0] out_next_r, out_next_nxt;
  logic [TIME_BITS-1:0] out_sleep_r, out_sleep_nxt;

  // Shared remainder step: shift in one dividend bit, subtract the period if it fits.
  logic [PB:0] trial, trial_diff;
  logic        trial_ge;
  assign trial      = {rem_r, div_r[DW-1]};
  assign trial_diff = trial - {1'b0, period_r};
  assign trial_ge   = (trial >= {1'b0, period_r});

  logic [31:0]          shift_mag;
  logic [TIME_BITS-1:0] elapsed;
  logic [PB-1:0]        seg_end;
  logic [SW-1:0]        due_sum;
  logic [TIME_BITS-1:0] time_max;
  logic [TIME_BITS-1:0] out_mask;

  assign shift_mag = time_shift_r[31] ? (~time_shift_r + 32'd1) : time_shift_r;
  assign elapsed   = now_r - TIME_BITS'(start_time_r);
  assign seg_end   = (acc_r[PB-1:0] < PB'(first_length_r)) ? PB'(first_length_r) : period_r;
  assign due_sum   = SW'(now_r) + SW'(acc_r[PB-1:0]);
  assign time_max  = '1;
  // Reported times keep only the low 32 bits.
  assign out_mask  = TIME_BITS'(64'hFFFF_FFFF);

  assign in_tready = (state_r == pset_pkg::S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    due_nxt       = due_r;
    next_nxt      = next_r;
    period_nxt    = period_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    shift_nxt     = shift_r;
    acc_nxt       = acc_r;
    code_nxt      = code_r;
    fired_nxt     = fired_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_fired_nxt = out_fired_r;
    out_empty_nxt = out_empty_r;
    out_code_nxt  = out_code_r;
    out_next_nxt  = out_next_r;
    out_sleep_nxt = out_sleep_r;

    case (state_r)
      pset_pkg::S_IDLE: begin
        if (in_tvalid) begin
          now_nxt   = in_tdata[TIME_BITS-1:0];
          state_nxt = pset_pkg::S_CHECK;
        end
      end
      pset_pkg::S_CHECK: begin
        period_nxt = PB'(first_length_r) + PB'(second_length_r);
        empty_nxt  = (first_length_r == '0) && (second_length_r == '0);
        fired_nxt  = 1'b0;
        code_nxt   = '0;
        if (empty_nxt) begin
          next_nxt  = time_max;
          state_nxt = pset_pkg::S_OUT;
        end else if (due_r > now_r) begin
          next_nxt  = due_r;
          state_nxt = pset_pkg::S_OUT;
        end else begin
          neg_nxt   = time_shift_r[31];
          div_nxt   = DW'(shift_mag);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = 1'b0;
          state_nxt = pset_pkg::S_DIV;
        end
      end
      pset_pkg::S_DIV: begin
        rem_nxt = trial_ge ? trial_diff[PB-1:0] : trial[PB-1:0];
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = phase_r ? pset_pkg::S_POS_ADD : pset_pkg::S_NEG;
        end
      end
      pset_pkg::S_NEG: begin
        // A negative shift maps to the period minus its reduced magnitude, or to zero if that is zero.
        shift_nxt = (neg_r && (rem_r != '0)) ? (period_r - rem_r) : rem_r;
        div_nxt   = DW'(elapsed);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = 1'b1;
        state_nxt = pset_pkg::S_DIV;
      end
      pset_pkg::S_POS_ADD: begin
        acc_nxt   = (PB+1)'(rem_r) + (PB+1)'(shift_r);
        state_nxt = pset_pkg::S_POS_WRAP;
      end
      pset_pkg::S_POS_WRAP: begin
        if (acc_r >= {1'b0, period_r}) begin
          acc_nxt = acc_r - {1'b0, period_r};
        end
        state_nxt = pset_pkg::S_SEG;
      end
      pset_pkg::S_SEG: begin
        code_nxt  = (acc_r[PB-1:0] < PB'(first_length_r)) ? first_event_r : second_event_r;
        acc_nxt   = (PB+1)'(seg_end - acc_r[PB-1:0]);
        state_nxt = pset_pkg::S_DUE;
      end
      pset_pkg::S_DUE: begin
        // A due time past the time range saturates at the maximum.
        due_nxt   = (due_sum[SW-1:TIME_BITS] != '0) ? time_max : due_sum[TIME_BITS-1:0];
        next_nxt  = due_nxt;
        fired_nxt = 1'b1;
        state_nxt = pset_pkg::S_OUT;
      end
      pset_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = fired_r;
          out_empty_nxt = empty_r;
          out_code_nxt  = EVENT_BITS'(code_r);
          out_next_nxt  = next_r & out_mask;
          out_sleep_nxt = ((next_r > now_r) ? (next_r - now_r) : '0) & out_mask;
          state_nxt     = pset_pkg::S_IDLE;
        end
      end
      default: state_nxt = pset_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pset_pkg::S_IDLE;
      due_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      due_r       <= due_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    next_r      <= next_nxt;
    period_r    <= period_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    phase_r     <= phase_nxt;
    neg_r       <= neg_nxt;
    shift_r     <= shift_nxt;
    acc_r       <= acc_nxt;
    code_r      <= code_nxt;
    fired_r     <= fired_nxt;
    empty_r     <= empty_nxt;
    out_fired_r <= out_fired_nxt;
    out_empty_r <= out_empty_nxt;
    out_code_r  <= out_code_nxt;
    out_next_r  <= out_next_nxt;
    out_sleep_r <= out_sleep_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_sleep_r, out_next_r, out_code_r});
  assign out_tuser  = {out_empty_r, out_fired_r};

endmodule

### hw/rtl/pset_chk.sv
// Port-level checker for the periodic segment event timer and its bind.
// Depends on periodic_segment_event_timer_unit; uses no package items.
module pset_chk #(
  parameter int TIME_BITS  = 32,
  parameter int EVENT_BITS = 16
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        in_tvalid,
  input logic                                        in_tready,
  input logic                                        out_tvalid,
  input logic                                        out_tready,
  input logic [((EVENT_BITS+2*TIME_BITS+7)/8)*8-1:0] out_tdata,
  input logic [1:0]                                  out_tuser
);

  logic [EVENT_BITS-1:0] code;
  logic [TIME_BITS-1:0]  next_due;
  logic [TIME_BITS-1:0]  max_due;

  assign code     = out_tdata[EVENT_BITS-1:0];
  assign next_due = out_tdata[EVENT_BITS+TIME_BITS-1:EVENT_BITS];
  assign max_due  = TIME_BITS'(64'hFFFF_FFFF);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  a_code_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> code == '0)
    else $error("event code set without a fired event");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && next_due == max_due)
    else $error("empty period fired or reported a finite due time");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in work");

endmodule

bind periodic_segment_event_timer_unit pset_chk #(
  .TIME_BITS (TIME_BITS),
  .EVENT_BITS(EVENT_BITS)
) u_pset_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

### dv/tb_periodic_segment_event_timer_unit.sv
// Testbench for periodic_segment_event_timer_unit: drives time requests and register writes,
// predicts every result in a scoreboard class and checks it field by field.
// Depends on pset_pkg and the top level of the timer.
module tb_periodic_segment_event_timer_unit;

  typedef struct packed {
    logic        fired;
    logic [15:0] event_code;
    logic [31:0] next_due;
    logic [31:0] sleep_seconds;
    logic        period_empty;
  } timer_report_t;

  class pset_event_tracker;
    logic [31:0] start_time;
    logic [31:0] time_shift;
    logic [31:0] first_len;
    logic [31:0] second_len;
    logic [15:0] first_ev;
    logic [15:0] second_ev;
    logic [31:0] due_time;
    timer_report_t pending_reports[$];
    int errors;

    function new();
      start_time = '0;
      time_shift = '0;
      first_len  = '0;
      second_len = '0;
      first_ev   = '0;
      second_ev  = '0;
      due_time   = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [pset_pkg::CFG_ADDR_BITS-1:0] idx, logic [31:0] val);
      case (idx)
        pset_pkg::REG_START_TIME:    start_time = val;
        pset_pkg::REG_TIME_SHIFT:    time_shift = val;
        pset_pkg::REG_FIRST_LENGTH:  first_len  = val;
        pset_pkg::REG_FIRST_EVENT:   first_ev   = val[15:0];
        pset_pkg::REG_SECOND_LENGTH: second_len = val;
        pset_pkg::REG_SECOND_EVENT:  second_ev  = val[15:0];
        default: ;
      endcase
    endfunction

    // Signed shift brought into [0, period); the period is non-zero here.
    function logic [32:0] folded_shift(logic [32:0] period);
      logic [32:0] mag;
      if (!time_shift[31]) return {1'b0, time_shift} % period;
      mag = (33'h1_0000_0000 - {1'b0, time_shift}) % period;
      return (mag == '0) ? '0 : period - mag;
    endfunction

    function void note_poll(logic [31:0] now);
      logic [32:0] period;
      logic [32:0] shift;
      logic [32:0] elapsed;
      logic [32:0] pos;
      logic [32:0] seg_end;
      logic [33:0] due_sum;
      timer_report_t exp_rep;
      period = {1'b0, first_len} + {1'b0, second_len};
      exp_rep = '0;
      if (period == '0) begin
        exp_rep.period_empty = 1'b1;
        exp_rep.next_due = '1;
      end else begin
        if (due_time <= now) begin
          shift = folded_shift(period);
          elapsed = {1'b0, now - start_time} % period;
          pos = 33'(({1'b0, elapsed} + {1'b0, shift}) % {1'b0, period});
          if (pos < {1'b0, first_len}) begin
            seg_end = {1'b0, first_len};
            exp_rep.event_code = first_ev;
          end else begin
            seg_end = period;
            exp_rep.event_code = second_ev;
          end
          due_sum = {2'b00, now} + {1'b0, seg_end - pos};
          // A due time past the end of the time range sticks at the maximum.
          due_time = (due_sum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : due_sum[31:0];
          exp_rep.fired = 1'b1;
        end
        exp_rep.next_due = due_time;
      end
      exp_rep.sleep_seconds = (exp_rep.next_due <= now) ? '0 : exp_rep.next_due - now;
      pending_reports.push_back(exp_rep);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(timer_report_t got);
      timer_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result arrived with no request pending");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      match_field("fired", 32'(want.fired), 32'(got.fired));
      match_field("event_code", 32'(want.event_code), 32'(got.event_code));
      match_field("next_due", want.next_due, got.next_due);
      match_field("sleep_seconds", want.sleep_seconds, got.sleep_seconds);
      match_field("period_empty", 32'(want.period_empty), 32'(got.period_empty));
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;

  int ready_pct;
  bit hold_off_req;
  int burst_left;

  pset_event_tracker tracker = new();

  always #5 clk = ~clk;

  periodic_segment_event_timer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Register writes, accepted requests and accepted results, all seen at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) tracker.write_reg(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) tracker.note_poll(in_tdata);
      if (out_tvalid && out_tready) begin
        tracker.check_report({out_tuser[0], out_tdata[15:0], out_tdata[47:16],
                              out_tdata[79:48], out_tuser[1]});
      end
    end
  end

  // Result side: switches between stall densities on its own, and on request holds off
  // for a long stretch so the block backs up into its input.
  initial begin
    int hold_cnt;
    int pattern_left;
    out_tready = 1'b0;
    ready_pct = 100;
    pattern_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 400; hold_cnt++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (pattern_left == 0) begin
        case ($urandom_range(3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
        pattern_left = $urandom_range(20, 300);
      end
      pattern_left--;
      out_tready <= ($urandom_range(99) < ready_pct);
    end
  end

  task automatic send_poll(input logic [31:0] now);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= now;
    do begin
      @(posedge clk);
    end while (!in_tready);
  endtask

  task automatic offer_poll(input logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_poll(now);
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Registers are only rewritten once every pending request has been answered.
  task automatic set_timer(input logic [31:0] start, input logic [31:0] shift,
                           input logic [31:0] f_len, input logic [31:0] f_ev,
                           input logic [31:0] s_len, input logic [31:0] s_ev);
    drain_reports();
    program_reg(pset_pkg::REG_START_TIME, start);
    program_reg(pset_pkg::REG_TIME_SHIFT, shift);
    program_reg(pset_pkg::REG_FIRST_LENGTH, f_len);
    program_reg(pset_pkg::REG_FIRST_EVENT, f_ev);
    program_reg(pset_pkg::REG_SECOND_LENGTH, s_len);
    program_reg(pset_pkg::REG_SECOND_EVENT, s_ev);
  endtask

  // Mostly a clock that moves forward from base in steps comparable to the period, or up
  // to 1000 for kind 4; some polls step back and some are taken at random up to the due time.
  task automatic run_phase(input int kind, input int count, input logic [31:0] base,
                           input bit squeeze);
    logic [31:0] f_len;
    logic [31:0] s_len;
    logic [31:0] shift;
    logic [31:0] stride;
    logic [31:0] t;
    logic [31:0] now;
    logic [32:0] ahead;
    int pick;
    case ($urandom_range(3))
      0: shift = 32'h8000_0000;
      1: shift = 32'h7FFF_FFFF;
      default: shift = $urandom;
    endcase
    case (kind)
      0: begin
        f_len = $urandom_range(12);
        s_len = $urandom_range(12);
      end
      1: begin
        f_len = $urandom_range(1, 5000);
        s_len = $urandom_range(1, 5000);
      end
      2: begin
        f_len = $urandom_range(1, 1000);
        s_len = 0;
        if ($urandom_range(1) == 1) begin
          s_len = f_len;
          f_len = 0;
        end
      end
      3: begin
        f_len = $urandom_range(1 << 20);
        s_len = $urandom_range(1 << 20);
      end
      default: begin
        f_len = $urandom;
        s_len = $urandom;
      end
    endcase
    set_timer($urandom, shift, f_len, $urandom, s_len, $urandom);
    if (squeeze) hold_off_req = 1'b1;
    if (kind == 0) stride = f_len + s_len + 1;
    else if (kind > 3) stride = 1000;
    else stride = (f_len + s_len) / 3 + 1;
    t = base;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        now = $urandom_range(tracker.due_time);
      end else if (pick < 10) begin
        now = t - $urandom_range(stride);
      end else begin
        ahead = {1'b0, t} + $urandom_range(stride);
        t = ahead[32] ? 32'hFFFF_FFFF : ahead[31:0];
        now = t;
      end
      offer_poll(now);
    end
  endtask

  initial begin
    int phase;
    int kind;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_off_req = 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Right after reset the period is empty.
    offer_poll(0);
    offer_poll(32'd12345);
    set_timer(100, 0, 10, 32'hAAAA, 5, 32'h5555);
    offer_poll(100);
    offer_poll(109);
    offer_poll(110);
    offer_poll(115);
    offer_poll(40);
    offer_poll(200);
    // Upper bits of the event registers must be dropped.
    set_timer(300, 32'h8000_0000, 7, 32'h0001_0001, 3, 32'hFFFF_FFFF);
    offer_poll(300);
    offer_poll(310);
    set_timer(0, 32'h7FFF_FFFF, 0, 32'h1234, 9, 32'h4321);
    offer_poll(400);
    offer_poll(409);
    // Start time later than the polled time, so the elapsed time wraps.
    set_timer(500, 32'hFFFF_FFFD, 6, 32'hBEEF, 0, 32'h00FF);
    offer_poll(450);
    offer_poll(460);
    // Emptying the period must leave the due time alone.
    set_timer(0, 5, 0, 7, 0, 9);
    offer_poll(470);
    offer_poll(32'hFFFF_FFFF);
    set_timer(1000, 32'hFFFF_FFFF, 4, 32'h0F0F, 4, 32'hF0F0);
    offer_poll(480);
    offer_poll(1000);
    offer_poll(1003);

    for (phase = 0; phase < 11; phase++) begin
      kind = (phase == 5) ? 0 : $urandom_range(3);
      run_phase(kind, 100, ((phase + 1) << 28) | $urandom_range((1 << 27) - 1), phase == 5);
    end
    // The top of the time range last: once the due time saturates it stays there.
    run_phase(4, 100, 32'hFFFF_FFFF - $urandom_range(30000), 1'b0);
    set_timer(0, 0, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'h8000);
    offer_poll(32'hFFFF_FFFF);
    offer_poll(32'hFFFF_FFFE);
    offer_poll(32'hFFFF_FFFF);

    drain_reports();
    repeat (80) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
